FILE: sv/mtg_pkg.sv
`default_nettype none
package mtg_pkg;

	localparam int STATE_LEN    = 624;
	localparam int TWIST_OFFSET = 397;
	localparam int IDX_W        = 10;
	localparam int WORD_W       = 32;

	localparam logic [IDX_W-1:0]  NEVER_SEEDED = IDX_W'(STATE_LEN + 1);
	localparam logic [IDX_W-1:0]  LAST_IDX     = IDX_W'(STATE_LEN - 1);
	localparam logic [IDX_W-1:0]  FULL_IDX     = IDX_W'(STATE_LEN);

	localparam logic [WORD_W-1:0] DEFAULT_SEED = 32'd5489;
	localparam logic [WORD_W-1:0] TWIST_MATRIX = 32'h9908_B0DF;
	localparam logic [WORD_W-1:0] HIGH_BIT     = 32'h8000_0000;
	localparam logic [WORD_W-1:0] LOW_BITS     = 32'h7FFF_FFFF;
	localparam logic [WORD_W-1:0] SEED_MULT    = 32'd1812433253;
	localparam logic [WORD_W-1:0] TEMPER_B     = 32'h9D2C_5680;
	localparam logic [WORD_W-1:0] TEMPER_C     = 32'hEFC6_0000;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SEED_MUL,
		ST_SEED_WR,
		ST_TW_PRE,
		ST_TW_LD,
		ST_TW_RD,
		ST_TW_WR,
		ST_DR_RD,
		ST_DR_OUT
	} mtg_state_t;

	typedef struct packed {
		logic seed_start;
		logic seed_dflt;
		logic seed_mul;
		logic seed_wr;
		logic tw_pre;
		logic tw_ld;
		logic tw_rd;
		logic tw_wr;
		logic dr_rd;
		logic dr_out;
	} mtg_cmd_t;

	typedef struct packed {
		logic cnt_last;
		logic seeded;
		logic twist_due;
		logic out_free;
	} mtg_stat_t;

	function automatic logic [WORD_W-1:0] temper(input logic [WORD_W-1:0] x);
		logic [WORD_W-1:0] y;
		y = x;
		y = y ^ (y >> 11);
		y = y ^ ((y << 7) & TEMPER_B);
		y = y ^ ((y << 15) & TEMPER_C);
		y = y ^ (y >> 18);
		return y;
	endfunction

endpackage
`default_nettype wire

FILE: sv/mtg_if.sv
`default_nettype none
interface mtg_req_if;
	logic        valid;
	logic        ready;
	logic        mode;
	logic [31:0] seed;

	modport source (output valid, output mode, output seed, input ready);
	modport sink   (input valid, input mode, input seed, output ready);
endinterface

interface mtg_res_if;
	logic        valid;
	logic        ready;
	logic [31:0] value;

	modport source (output valid, output value, input ready);
	modport sink   (input valid, input value, output ready);
endinterface
`default_nettype wire

FILE: sv/mtg_dp.sv
`default_nettype none
module mtg_dp (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire mtg_pkg::mtg_cmd_t         cmd,
	output mtg_pkg::mtg_stat_t             stat,
	input  wire logic [mtg_pkg::WORD_W-1:0] seed,
	output logic                           out_valid,
	output logic [mtg_pkg::WORD_W-1:0]     out_value,
	input  wire logic                      out_ready
);
	import mtg_pkg::*;

	logic [WORD_W-1:0] mem [STATE_LEN];
	logic [WORD_W-1:0] rd_a_q, rd_b_q;
	logic [WORD_W-1:0] prev_q, prod_q;
	logic [IDX_W-1:0]  cnt_q, idx_q;
	logic              out_valid_q;
	logic [WORD_W-1:0] out_q;

	logic [WORD_W-1:0] seed_src, mix, seed_val, y, tw_val, mag;
	logic [IDX_W-1:0]  nxt, far, addr_a, wr_addr;
	logic [IDX_W:0]    far_sum;
	logic              rd_en, wr_en;
	logic [WORD_W-1:0] wr_data;

	assign seed_src = cmd.seed_dflt ? DEFAULT_SEED : seed;
	assign mix      = prev_q ^ (prev_q >> 30);
	assign seed_val = prod_q + {{(WORD_W-IDX_W){1'b0}}, cnt_q};

	assign nxt     = (cnt_q == LAST_IDX) ? '0 : cnt_q + 1'b1;
	assign far_sum = {1'b0, cnt_q} + (IDX_W+1)'(TWIST_OFFSET);
	assign far     = (far_sum >= (IDX_W+1)'(STATE_LEN))
		? IDX_W'(far_sum - (IDX_W+1)'(STATE_LEN)) : IDX_W'(far_sum);

	assign y      = (prev_q & HIGH_BIT) | (rd_a_q & LOW_BITS);
	assign mag    = y[0] ? TWIST_MATRIX : '0;
	assign tw_val = rd_b_q ^ (y >> 1) ^ mag;

	always_comb begin
		addr_a = idx_q;
		if (cmd.tw_pre) begin
			addr_a = '0;
		end else if (cmd.tw_rd) begin
			addr_a = nxt;
		end
	end

	assign rd_en = cmd.tw_pre | cmd.tw_rd | cmd.dr_rd;
	assign wr_en = cmd.seed_start | cmd.seed_wr | cmd.tw_wr;

	always_comb begin
		wr_addr = cnt_q;
		wr_data = tw_val;
		if (cmd.seed_start) begin
			wr_addr = '0;
			wr_data = seed_src;
		end else if (cmd.seed_wr) begin
			wr_data = seed_val;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_a_q <= mem[addr_a];
			rd_b_q <= mem[far];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.seed_start) begin
			prev_q <= seed_src;
		end else if (cmd.seed_wr) begin
			prev_q <= seed_val;
		end else if (cmd.tw_ld || cmd.tw_wr) begin
			prev_q <= rd_a_q;
		end
		if (cmd.seed_mul) begin
			prod_q <= SEED_MULT * mix;
		end
		if (cmd.dr_out) begin
			out_q <= temper(rd_a_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			idx_q       <= NEVER_SEEDED;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.seed_start) begin
				cnt_q <= IDX_W'(1);
				idx_q <= FULL_IDX;
			end else if (cmd.seed_wr || cmd.tw_wr) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (cmd.tw_ld) begin
				cnt_q <= '0;
			end
			if (cmd.tw_wr && cnt_q == LAST_IDX) begin
				idx_q <= '0;
			end else if (cmd.dr_rd) begin
				idx_q <= idx_q + 1'b1;
			end
			if (cmd.dr_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign stat.cnt_last  = (cnt_q == LAST_IDX);
	assign stat.seeded    = (idx_q != NEVER_SEEDED);
	assign stat.twist_due = (idx_q >= FULL_IDX);
	assign stat.out_free  = !out_valid_q || out_ready;

	assign out_valid = out_valid_q;
	assign out_value = out_q;
endmodule
`default_nettype wire

FILE: sv/mtg_ctrl.sv
`default_nettype none
module mtg_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	input  wire logic               in_mode,
	output logic                    in_ready,
	input  wire mtg_pkg::mtg_stat_t stat,
	output mtg_pkg::mtg_cmd_t       cmd
);
	import mtg_pkg::*;

	mtg_state_t state_q, state_d;
	logic       draw_q, draw_d;
	logic       accept;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;

	always_comb begin
		state_d = state_q;
		draw_d  = draw_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					draw_d = in_mode;
					if (!in_mode || !stat.seeded) begin
						state_d = ST_SEED_MUL;
					end else if (stat.twist_due) begin
						state_d = ST_TW_PRE;
					end else begin
						state_d = ST_DR_RD;
					end
				end
			end
			ST_SEED_MUL: state_d = ST_SEED_WR;
			ST_SEED_WR: begin
				if (!stat.cnt_last) begin
					state_d = ST_SEED_MUL;
				end else if (draw_q) begin
					state_d = ST_TW_PRE;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_TW_PRE: state_d = ST_TW_LD;
			ST_TW_LD:  state_d = ST_TW_RD;
			ST_TW_RD:  state_d = ST_TW_WR;
			ST_TW_WR:  state_d = stat.cnt_last ? ST_DR_RD : ST_TW_RD;
			ST_DR_RD:  state_d = ST_DR_OUT;
			ST_DR_OUT: begin
				if (stat.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		case (state_q)
			ST_IDLE: begin
				if (accept && (!in_mode || !stat.seeded)) begin
					cmd.seed_start = 1'b1;
					cmd.seed_dflt  = in_mode;
				end
			end
			ST_SEED_MUL: cmd.seed_mul = 1'b1;
			ST_SEED_WR:  cmd.seed_wr  = 1'b1;
			ST_TW_PRE:   cmd.tw_pre   = 1'b1;
			ST_TW_LD:    cmd.tw_ld    = 1'b1;
			ST_TW_RD:    cmd.tw_rd    = 1'b1;
			ST_TW_WR:    cmd.tw_wr    = 1'b1;
			ST_DR_RD:    cmd.dr_rd    = 1'b1;
			ST_DR_OUT:   cmd.dr_out   = stat.out_free;
			default:     cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			draw_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			draw_q  <= draw_d;
		end
	end
endmodule
`default_nettype wire

FILE: sv/mersenne_twister_generator.sv
`default_nettype none
// channel | dir | transfer payload
// req     | in  | mode (0 reseed, 1 draw), seed[31:0]
// res     | out | value[31:0], one per draw
//
// Draw: when state words remain, DR_RD reads the word and DR_OUT tempers it
// into the output register once that register is free. A draw that finds the
// state used up first runs a full twist (one read pair and one write per word,
// single write port). Reseed: one multiply and one write per word after word 0.
// After reset the first draw also runs the 5489 reseed first.
// A finished result waits in the output register; a reseed is taken meanwhile.
module mersenne_twister_generator (
	input wire logic clk,
	input wire logic arst_n,
	mtg_req_if.sink   req,
	mtg_res_if.source res
);
	import mtg_pkg::*;

	mtg_cmd_t  cmd;
	mtg_stat_t stat;

	mtg_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_mode  (req.mode),
		.in_ready (req.ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	mtg_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.seed      (req.seed),
		.out_valid (res.valid),
		.out_value (res.value),
		.out_ready (res.ready)
	);
endmodule
`default_nettype wire

FILE: bench/mersenne_twister_generator_tb.sv
module mersenne_twister_generator_tb;

	localparam int          MT_N        = 624;
	localparam int          MT_M        = 397;
	localparam logic [9:0]  POS_FRESH   = 10'd625;
	localparam logic [31:0] INIT_MULT   = 32'd1812433253;
	localparam logic [31:0] BOOT_SEED   = 32'd5489;
	localparam logic [31:0] TWIST_XOR   = 32'h9908_B0DF;
	localparam logic [31:0] TOP_BIT     = 32'h8000_0000;
	localparam logic [31:0] LOW_31      = 32'h7FFF_FFFF;
	localparam logic [31:0] MASK_B      = 32'h9D2C_5680;
	localparam logic [31:0] MASK_C      = 32'hEFC6_0000;

	localparam logic MODE_RESEED = 1'b0;
	localparam logic MODE_DRAW   = 1'b1;

	localparam int TAIL_CYCLES = 1300;

	typedef struct {
		logic        mode;
		logic [31:0] seed;
		bit          known;
		logic [31:0] value;
	} stim_row_t;

	localparam int N_ROWS = 21;

	stim_row_t directed_rows [N_ROWS] = '{
		'{MODE_DRAW,   32'hFFFF_FFFF, 1'b1, 32'd3499211612},
		'{MODE_DRAW,   32'h0000_0000, 1'b1, 32'd581869302},
		'{MODE_DRAW,   32'h5A5A_5A5A, 1'b1, 32'd3890346734},
		'{MODE_RESEED, 32'h0000_0000, 1'b0, 32'd0},
		'{MODE_DRAW,   32'hA5A5_A5A5, 1'b1, 32'd2357136044},
		'{MODE_DRAW,   32'h0000_0000, 1'b0, 32'd0},
		'{MODE_RESEED, 32'h0000_0001, 1'b0, 32'd0},
		'{MODE_DRAW,   32'hFFFF_FFFF, 1'b1, 32'd1791095845},
		'{MODE_RESEED, 32'hFFFF_FFFF, 1'b0, 32'd0},
		'{MODE_DRAW,   32'h0000_0000, 1'b0, 32'd0},
		'{MODE_DRAW,   32'hFFFF_FFFF, 1'b0, 32'd0},
		'{MODE_RESEED, 32'h8000_0000, 1'b0, 32'd0},
		'{MODE_RESEED, 32'h7FFF_FFFF, 1'b0, 32'd0},
		'{MODE_DRAW,   32'h0000_0000, 1'b0, 32'd0},
		'{MODE_RESEED, 32'd5489,      1'b0, 32'd0},
		'{MODE_DRAW,   32'h1234_5678, 1'b1, 32'd3499211612},
		'{MODE_DRAW,   32'h0000_0000, 1'b1, 32'd581869302},
		'{MODE_RESEED, 32'h1234_5678, 1'b0, 32'd0},
		'{MODE_DRAW,   32'h0000_0000, 1'b0, 32'd0},
		'{MODE_RESEED, 32'd5489,      1'b0, 32'd0},
		'{MODE_DRAW,   32'hFFFF_FFFF, 1'b1, 32'd3499211612}
	};

	// idle mixes: none, sender 81%, receiver 81%, both 18%
	localparam int N_PHASES = 4;
	localparam int PH_ITEMS    [N_PHASES] = '{660, 300, 300, 270};
	localparam int PH_IDLE     [N_PHASES] = '{0, 81, 0, 18};
	localparam int PH_STALL    [N_PHASES] = '{0, 0, 81, 18};
	localparam int PH_RESEED_1IN [N_PHASES] = '{0, 12, 12, 25};

	logic clk;
	logic arst_n;

	mtg_req_if req_if ();
	mtg_res_if res_if ();

	mersenne_twister_generator DUT (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_if),
		.res(res_if)
	);

	logic [31:0] mt_words [MT_N];
	logic [9:0]  mt_pos;
	logic [31:0] pending_values [$];

	int sender_idle_pct;
	int recv_stall_pct;
	int mismatch_count;
	int values_checked;
	int reseeds_sent;
	int draws_sent;
	int twist_count;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#60_000_000;
		$display("Timeout: %0d values still pending", pending_values.size());
		$display("Mismatches found");
		$finish;
	end

	function automatic void fill_from_seed(logic [31:0] s);
		mt_words[10'd0] = s;
		for (int i = 1; i < MT_N; i++)
			mt_words[10'(i)] = INIT_MULT * (mt_words[10'(i-1)] ^ (mt_words[10'(i-1)] >> 30))
				+ 32'(i);
		mt_pos = 10'(MT_N);
	endfunction

	function automatic void twist_words();
		logic [31:0] y;
		for (int k = 0; k < MT_N; k++) begin
			y = (mt_words[10'(k)] & TOP_BIT) | (mt_words[10'((k + 1) % MT_N)] & LOW_31);
			mt_words[10'(k)] = mt_words[10'((k + MT_M) % MT_N)] ^ (y >> 1)
				^ (y[0] ? TWIST_XOR : 32'd0);
		end
		mt_pos = 10'd0;
		twist_count++;
	endfunction

	function automatic logic [31:0] tempered(logic [31:0] w);
		logic [31:0] t;
		t = w ^ (w >> 11);
		t = t ^ ((t << 7) & MASK_B);
		t = t ^ ((t << 15) & MASK_C);
		return t ^ (t >> 18);
	endfunction

	function automatic logic [31:0] next_draw();
		logic [31:0] w;
		if (mt_pos >= 10'(MT_N)) begin
			if (mt_pos == POS_FRESH)
				fill_from_seed(BOOT_SEED);
			twist_words();
		end
		w = mt_words[mt_pos];
		mt_pos++;
		return tempered(w);
	endfunction

	function automatic void predict_transfer(logic m, logic [31:0] s, bit known,
			logic [31:0] typed);
		logic [31:0] v;
		if (m == MODE_RESEED) begin
			fill_from_seed(s);
			reseeds_sent++;
		end else begin
			v = next_draw();
			pending_values.push_back(known ? typed : v);
			draws_sent++;
		end
	endfunction

	task automatic report_mismatch(string msg);
		$display("MISMATCH @%0t: %s", $time, msg);
		mismatch_count++;
	endtask

	task automatic send_item(logic m, logic [31:0] s, bit known, logic [31:0] typed);
		while ($urandom_range(99) < sender_idle_pct) begin
			req_if.valid <= 1'b0;
			req_if.mode  <= 1'($urandom);
			req_if.seed  <= $urandom;
			@(posedge clk);
		end
		req_if.valid <= 1'b1;
		req_if.mode  <= m;
		req_if.seed  <= s;
		@(posedge clk);
		while (!req_if.ready)
			@(posedge clk);
		predict_transfer(m, s, known, typed);
	endtask

	task automatic drain_pending();
		req_if.valid <= 1'b0;
		do
			@(posedge clk);
		while (pending_values.size() != 0);
	endtask

	// result side: check at each edge, then pick next ready
	initial begin
		logic [31:0] exp_value;
		forever begin
			@(posedge clk);
			if (res_if.valid && res_if.ready) begin
				if (pending_values.size() == 0) begin
					report_mismatch($sformatf("unexpected value %h", res_if.value));
				end else begin
					exp_value = pending_values.pop_front();
					values_checked++;
					if (res_if.value !== exp_value)
						report_mismatch($sformatf("value %h, expected %h",
							res_if.value, exp_value));
				end
			end
			res_if.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	initial begin
		logic        m;
		logic [31:0] s;
		int          one_in;
		mismatch_count  = 0;
		values_checked  = 0;
		reseeds_sent    = 0;
		draws_sent      = 0;
		twist_count     = 0;
		sender_idle_pct = 0;
		recv_stall_pct  = 0;
		for (int i = 0; i < MT_N; i++)
			mt_words[10'(i)] = 32'd0;
		mt_pos = POS_FRESH;
		arst_n       <= 1'b0;
		req_if.valid <= 1'b0;
		req_if.mode  <= MODE_DRAW;
		req_if.seed  <= 32'd0;
		res_if.ready <= 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		for (int r = 0; r < N_ROWS; r++)
			send_item(directed_rows[5'(r)].mode, directed_rows[5'(r)].seed,
				directed_rows[5'(r)].known, directed_rows[5'(r)].value);
		drain_pending();

		for (int p = 0; p < N_PHASES; p++) begin
			sender_idle_pct = PH_IDLE[2'(p)];
			recv_stall_pct  = PH_STALL[2'(p)];
			one_in          = PH_RESEED_1IN[2'(p)];
			for (int n = 0; n < PH_ITEMS[2'(p)]; n++) begin
				if (n == 0)
					m = MODE_RESEED;
				else if (one_in != 0 && $urandom_range(one_in - 1) == 0)
					m = MODE_RESEED;
				else
					m = MODE_DRAW;
				s = $urandom;
				send_item(m, s, 1'b0, 32'd0);
			end
			drain_pending();
		end

		repeat (TAIL_CYCLES) @(posedge clk);
		if (pending_values.size() != 0)
			report_mismatch($sformatf("%0d values never arrived", pending_values.size()));

		$display("Covered %0d reseeds, %0d draws, %0d full twists, four idle mixes",
			reseeds_sent, draws_sent, twist_count);
		$display("%0d values checked, %0d mismatches", values_checked, mismatch_count);
		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
